FILE: hdl/ascii_text_sanitizer_defines.svh
// Assertion macros used by the sanitizer decision logic.
`ifndef ASCII_TEXT_SANITIZER_DEFINES_SVH
`define ASCII_TEXT_SANITIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition holds at every clock edge outside reset.
`define ATS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ascii_text_sanitizer: invariant violated");

// Checks that a consequence holds in the cycle after its trigger.
`define ATS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ascii_text_sanitizer: sequence violated");

`else

`define ATS_ASSERT_ALWAYS(label, clk, rst, expr)
`define ATS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/ats_pkg.sv
// Package with the constants and types of the ASCII text sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

   localparam int unsigned MAX_CAPACITY = 4096;
   localparam int unsigned CAP_WIDTH    = 13;
   localparam int unsigned COUNT_WIDTH  = 12;

   localparam logic [CAP_WIDTH-1:0] CAP_LIMIT     = CAP_WIDTH'(MAX_CAPACITY);
   localparam logic [CAP_WIDTH-1:0] CAP_RESET     = CAP_WIDTH'(4096);

   localparam logic [7:0] BYTE_NUL         = 8'h00;
   localparam logic [7:0] BYTE_TAB         = 8'h09;
   localparam logic [7:0] BYTE_NEWLINE     = 8'h0A;
   localparam logic [7:0] BYTE_RETURN      = 8'h0D;
   localparam logic [7:0] PRINT_LOW        = 8'd32;
   localparam logic [7:0] PRINT_HIGH       = 8'd126;
   localparam logic [7:0] SPACE_CHAR       = 8'h20;
   localparam logic [7:0] REPLACEMENT_CHAR = 8'h3F;
   localparam logic [7:0] CONT_MASK        = 8'hC0;
   localparam logic [7:0] CONT_MARK        = 8'h80;

   // One raw byte held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
   } ats_req_type;

   // One result item.
   typedef struct packed {
      logic                   is_final;
      logic [COUNT_WIDTH-1:0] char_position;
      logic [7:0]             char_value;
      logic [COUNT_WIDTH-1:0] final_length;
   } ats_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/ascii_text_sanitizer.sv
// Top level of the ASCII text sanitizer.
//
// The block takes one byte of a zero-terminated string per request on the
// req_ channel and returns sanitized characters on the rsp_ channel. Printable
// bytes pass through, newline, return and tab become a single space after a
// non-space character, and other bytes become '?', with UTF-8 continuation
// bytes after a replacement dropped. Each character carries its buffer
// position. A zero byte returns the trimmed length with rsp_is_final set.
// Bytes that would overflow the buffer, and bytes that are dropped, give no
// response. The capacity register is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. An accepted request is decided from the
// input register and its response loaded into the result register when that
// has room. One request can be accepted every cycle while the receiver does
// not stall: an input register and a result register sit on either side of
// the decision logic. When the receiver stalls, the result register holds its
// response, the input register takes at most one more byte, and req_ready
// stays low until the result register drains. Reset empties both registers,
// clears the string state and sets the capacity to 4096.
`timescale 1ns / 1ps
`default_nettype none

module ascii_text_sanitizer
   import ats_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_in_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_is_final,
   output logic [COUNT_WIDTH-1:0]      rsp_char_position,
   output logic [7:0]                  rsp_char_value,
   output logic [COUNT_WIDTH-1:0]      rsp_final_length,
   input  wire logic                   csr_wr_en,
   input  wire logic [CAP_WIDTH-1:0]   csr_wr_data
);

   logic [CAP_WIDTH-1:0] capacity_ff;
   ats_req_type          held;
   ats_rsp_type          result;
   ats_rsp_type          rsp_data;
   logic                 take;
   logic                 produce;
   logic                 out_ready;

   // Capacity register; values above the buffer limit saturate downstream.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   ats_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .take        (take),
      .held        (held)
   );

   ats_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .held      (held),
      .capacity  (capacity_ff),
      .out_ready (out_ready),
      .take      (take),
      .produce   (produce),
      .result    (result)
   );

   ats_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .produce   (produce),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_is_final      = rsp_data.is_final;
   assign rsp_char_position = rsp_data.char_position;
   assign rsp_char_value    = rsp_data.char_value;
   assign rsp_final_length  = rsp_data.final_length;

endmodule

`default_nettype wire

FILE: hdl/ats_in_reg.sv
// Input register that holds one accepted request byte.
`timescale 1ns / 1ps
`default_nettype none

module ats_in_reg
   import ats_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        take,
   output ats_req_type      held
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // The register refills in the same cycle it is drained.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held.valid   = valid_ff;
   assign held.in_byte = byte_ff;

endmodule

`default_nettype wire

FILE: hdl/ats_decide.sv
// Per-byte decision logic and the string state of the sanitizer.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_text_sanitizer_defines.svh"

module ats_decide
   import ats_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  ats_req_type               held,
   input  wire logic [CAP_WIDTH-1:0] capacity,
   input  wire logic                 out_ready,
   output logic                      take,
   output logic                      produce,
   output ats_rsp_type               result
);

   logic [COUNT_WIDTH-1:0] written_count_ff, written_count_in;
   logic [COUNT_WIDTH-1:0] trimmed_length_ff, trimmed_length_in;
   logic                   replacing_ff, replacing_in;

   logic [CAP_WIDTH-1:0]   cap_eff;
   logic [CAP_WIDTH-1:0]   next_count;
   logic                   full;
   logic                   printable;
   logic                   whitespace;
   logic                   continuation;
   logic                   is_nul;
   logic                   emit;
   logic [7:0]             emit_char;

   assign take = held.valid && out_ready;

   assign cap_eff      = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
   assign next_count   = {1'b0, written_count_ff} + CAP_WIDTH'(1);
   assign full         = (cap_eff == '0) || (next_count >= cap_eff);
   assign is_nul       = held.in_byte == BYTE_NUL;
   assign printable    = (held.in_byte >= PRINT_LOW) && (held.in_byte <= PRINT_HIGH);
   assign whitespace   = (held.in_byte == BYTE_NEWLINE) || (held.in_byte == BYTE_RETURN)
                         || (held.in_byte == BYTE_TAB);
   assign continuation = (held.in_byte & CONT_MASK) == CONT_MARK;

   always_comb begin
      emit         = 1'b0;
      emit_char    = REPLACEMENT_CHAR;
      replacing_in = replacing_ff;
      priority if (is_nul || full) begin
         emit = 1'b0;
      end else if (printable) begin
         replacing_in = 1'b0;
         emit         = 1'b1;
         emit_char    = held.in_byte;
      end else if (whitespace) begin
         // A space is written only after a non-space character.
         replacing_in = 1'b0;
         emit         = (written_count_ff != '0) && (written_count_ff == trimmed_length_ff);
         emit_char    = SPACE_CHAR;
      end else if (!continuation || !replacing_ff) begin
         replacing_in = 1'b1;
         emit         = 1'b1;
      end else begin
         emit = 1'b0;
      end
   end

   always_comb begin
      written_count_in  = written_count_ff;
      trimmed_length_in = trimmed_length_ff;
      if (emit) begin
         written_count_in = next_count[COUNT_WIDTH-1:0];
         if (emit_char != SPACE_CHAR) begin
            trimmed_length_in = next_count[COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_count_ff  <= '0;
         trimmed_length_ff <= '0;
         replacing_ff      <= 1'b0;
      end else if (take) begin
         if (is_nul) begin
            written_count_ff  <= '0;
            trimmed_length_ff <= '0;
            replacing_ff      <= 1'b0;
         end else begin
            written_count_ff  <= written_count_in;
            trimmed_length_ff <= trimmed_length_in;
            replacing_ff      <= replacing_in;
         end
      end
   end

   assign produce              = take && (is_nul || emit);
   assign result.is_final      = is_nul;
   assign result.char_position = is_nul ? '0 : written_count_ff;
   assign result.char_value    = is_nul ? 8'h00 : emit_char;
   assign result.final_length  = is_nul ? trimmed_length_ff : '0;

   `ATS_ASSERT_ALWAYS(a_trim_within_count, clock, reset,
      trimmed_length_ff <= written_count_ff)
   `ATS_ASSERT_NEXT(a_char_advances_count, clock, reset, produce && !is_nul,
      written_count_ff == COUNT_WIDTH'($past(written_count_ff) + COUNT_WIDTH'(1)))
   `ATS_ASSERT_NEXT(a_final_clears_state, clock, reset, take && is_nul,
      (written_count_ff == '0) && (trimmed_length_ff == '0) && !replacing_ff)

endmodule

`default_nettype wire

FILE: hdl/ats_out_reg.sv
// Result register that holds one finished result until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module ats_out_reg
   import ats_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  wire logic  produce,
   input  ats_rsp_type result,
   output logic       out_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output ats_rsp_type rsp_data
);

   logic        valid_ff, valid_in;
   ats_rsp_type data_ff, data_in;

   // Room when empty or when the held result leaves this cycle.
   assign out_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = produce;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the ASCII text sanitizer.
`timescale 1ns / 1ps

module tb_top;
   import ats_pkg::*;

   // The receiver holds off this long once, so that the block fills up and
   // stalls its request channel.
   localparam int unsigned LONG_HOLD = 300;
   // Cycles allowed after the last expected response for a byte that gives
   // no response to leave the pipeline. The block has two stages.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PRINT_BUDGET = 40;

   // One queued request byte. The gap is the idle time the driver leaves
   // after the byte is taken. A byte marked to wait for drain is not offered
   // until every expected response has arrived.
   typedef struct {
      logic [7:0]  value;
      int unsigned gap;
      bit          drain;
   } text_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_in_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_is_final;
   logic [COUNT_WIDTH-1:0] rsp_char_position;
   logic [7:0]             rsp_char_value;
   logic [COUNT_WIDTH-1:0] rsp_final_length;
   logic                   csr_wr_en = 1'b0;
   logic [CAP_WIDTH-1:0]   csr_wr_data = '0;

   // Request bytes waiting for the driver, and the responses the sanitizer
   // is expected to give, oldest first.
   text_byte_type byte_queue[$];
   ats_rsp_type   expected_text[$];

   // The capacity as last written, and the string state of the predictor.
   logic [CAP_WIDTH-1:0] cap_setting = CAP_RESET;
   int unsigned          str_written = 0;
   int unsigned          str_trimmed = 0;
   bit                   str_replacing = 1'b0;

   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned holds_wanted = 0;
   int unsigned holds_served = 0;
   // While set, neither side idles or stalls on its own.
   bit          phase_no_idle = 1'b0;

   // Directed opening text under the reset capacity. It starts with
   // whitespace on an empty buffer, puts whitespace after a space, replaces
   // a two-byte sequence and drops its continuation bytes, drops a
   // continuation after a replaced control byte, replaces a stray
   // continuation once a printable character has broken the run, replaces
   // DEL and 0xFF, and ends with trailing spaces that the length report
   // trims. An empty string follows, then whitespace right after a
   // replacement, which is written as a space and ends the run.
   logic [7:0] opening [0:26] = '{
      BYTE_NEWLINE, 8'h41, SPACE_CHAR, BYTE_TAB, PRINT_HIGH, BYTE_RETURN,
      BYTE_NEWLINE, 8'hC3, 8'hA9, 8'h80, 8'hBF, 8'h01, 8'h80, 8'h78,
      8'h80, 8'h80, 8'h7F, 8'hFF, 8'h1F, BYTE_TAB, SPACE_CHAR, BYTE_NUL,
      BYTE_NUL, 8'hE2, BYTE_NEWLINE, 8'h80, BYTE_NUL
   };

   ascii_text_sanitizer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_final      (rsp_is_final),
      .rsp_char_position (rsp_char_position),
      .rsp_char_value    (rsp_char_value),
      .rsp_final_length  (rsp_final_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned k;
      if (phase_no_idle) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 90) return $urandom_range(1, 3);
      if (k < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Writes one character into the predicted buffer and builds its response.
   function automatic void write_char(input logic [7:0] ch, output ats_rsp_type r);
      r = '0;
      r.char_position = COUNT_WIDTH'(str_written);
      r.char_value = ch;
      str_written++;
      if (ch != SPACE_CHAR) str_trimmed = str_written;
   endfunction

   // Predicts the sanitizer's decision for one byte. Returns 1 when the byte
   // gives a response, which is then left in r.
   function automatic bit sanitize_byte(input logic [7:0] b, output ats_rsp_type r);
      int unsigned cap;
      r = '0;
      // Capacities above the buffer size saturate.
      cap = (cap_setting > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_setting);
      if (b == BYTE_NUL) begin
         r.is_final = 1'b1;
         r.final_length = COUNT_WIDTH'(str_trimmed);
         str_written = 0;
         str_trimmed = 0;
         str_replacing = 1'b0;
         return 1'b1;
      end
      // One slot is kept for the terminator; a full buffer ignores the byte.
      if (cap == 0 || str_written + 1 >= cap) return 1'b0;
      if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
         str_replacing = 1'b0;
         write_char(b, r);
         return 1'b1;
      end
      if (b == BYTE_NEWLINE || b == BYTE_RETURN || b == BYTE_TAB) begin
         str_replacing = 1'b0;
         // Only one space, and never at the start of the buffer.
         if (str_written != 0 && str_written == str_trimmed) begin
            write_char(SPACE_CHAR, r);
            return 1'b1;
         end
         return 1'b0;
      end
      if ((b & CONT_MASK) != CONT_MARK || !str_replacing) begin
         str_replacing = 1'b1;
         write_char(REPLACEMENT_CHAR, r);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_BUDGET)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic queue_byte(input logic [7:0] v);
      text_byte_type t;
      t.value = v;
      t.gap = pick_gap();
      t.drain = 1'b0;
      byte_queue.push_back(t);
      bytes_queued++;
   endtask

   // Queues a random string built from well-formed pieces: printable runs,
   // whitespace, multibyte sequences, stray continuations, control and high
   // bytes. Its first byte may wait until the block has drained.
   task automatic queue_random_string(input int unsigned len, input bit terminate,
                                      input bit force_drain);
      int unsigned n;
      int unsigned k;
      int unsigned start;
      start = byte_queue.size();
      n = 0;
      while (n < len) begin
         k = $urandom_range(0, 99);
         if (k < 55) begin
            queue_byte(8'($urandom_range(32, 126)));
         end else if (k < 65) begin
            case ($urandom_range(0, 2))
               0: begin
                  queue_byte(BYTE_TAB);
               end
               1: begin
                  queue_byte(BYTE_NEWLINE);
               end
               default: begin
                  queue_byte(BYTE_RETURN);
               end
            endcase
         end else if (k < 80) begin
            queue_byte(8'($urandom_range(8'hC2, 8'hF4)));
            repeat ($urandom_range(1, 3)) begin
               queue_byte(8'($urandom_range(8'h80, 8'hBF)));
               n++;
            end
         end else if (k < 88) begin
            queue_byte(8'($urandom_range(8'h80, 8'hBF)));
         end else if (k < 95) begin
            queue_byte(8'($urandom_range(1, 31)));
         end else begin
            queue_byte(8'($urandom_range(127, 255)));
         end
         n++;
      end
      if (terminate) queue_byte(BYTE_NUL);
      if ((force_drain || $urandom_range(0, 7) == 0) && byte_queue.size() > start)
         byte_queue[start].drain = 1'b1;
   endtask

   // Waits until every queued request has been taken and every expected
   // response has arrived, then lets a byte with no response leave the
   // pipeline as well.
   task automatic wait_quiet();
      while (bytes_accepted != bytes_queued || expected_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Called only while the block is idle, so the predictor can take the new
   // capacity at once.
   task automatic write_capacity(input logic [CAP_WIDTH-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      cap_setting = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CAP_WIDTH-1:0] pick_capacity();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return CAP_WIDTH'(1);
         2: return CAP_WIDTH'(2);
         3: return '1;
         4: return CAP_LIMIT;
         5: return CAP_WIDTH'($urandom_range(MAX_CAPACITY + 1, 8190));
         6, 7, 8, 9: return CAP_WIDTH'($urandom_range(3, 12));
         default: return CAP_WIDTH'($urandom_range(13, 80));
      endcase
   endfunction

   // Driver. A byte stays offered until it is taken; the next byte, or a
   // gap, follows at the edge that takes it.
   always @(posedge clock) begin : request_driver
      int unsigned   gap_left;
      text_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0 &&
                      (!byte_queue[0].drain || (!req_valid && expected_text.size() == 0))) begin
            // A drain byte waits until no request is offered, so that the
            // expectation of the last request is already in the queue.
            next_byte = byte_queue.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= next_byte.value;
            gap_left = next_byte.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. It stalls at random, and once for a long stretch on demand.
   always @(posedge clock) begin : response_receiver
      int unsigned stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (holds_served != holds_wanted) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !phase_no_idle && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor. A request taken at this edge is predicted before the response
   // taken at the same edge is checked; a response can never belong to a
   // request taken at the same edge.
   always @(posedge clock) begin : text_monitor
      ats_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            bytes_accepted++;
            if (sanitize_byte(req_in_byte, want)) expected_text.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_BUDGET)
                  $display("%0t: response with none expected, actual final=%0d pos=%0d char=%0d len=%0d",
                           $time, rsp_is_final, rsp_char_position, rsp_char_value,
                           rsp_final_length);
            end else begin
               want = expected_text.pop_front();
               check_field("is_final", want.is_final, rsp_is_final);
               check_field("char_position", want.char_position, rsp_char_position);
               check_field("char_value", want.char_value, rsp_char_value);
               check_field("final_length", want.final_length, rsp_final_length);
            end
         end
      end
   end

   initial begin : stimulus
      logic [CAP_WIDTH-1:0] tiny_caps [0:2];
      int unsigned phase_start;
      int unsigned len;
      tiny_caps = '{'0, CAP_WIDTH'(1), CAP_WIDTH'(2)};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The opening text runs under the capacity left by reset.
      foreach (opening[i]) queue_byte(opening[i]);

      // Zero capacity reports length 0; capacity 1 writes nothing and
      // capacity 2 writes one character before the buffer is full.
      foreach (tiny_caps[i]) begin
         wait_quiet();
         write_capacity(tiny_caps[i]);
         queue_byte(8'h61);
         queue_byte(8'h62);
         queue_byte(BYTE_TAB);
         queue_byte(BYTE_NUL);
      end

      // Random phases, each under its own capacity. Some phases run with no
      // idling, and one of them starts with a long receiver hold while the
      // sender keeps offering printable-heavy text.
      for (int phase = 0; phase < 10; phase++) begin
         wait_quiet();
         phase_no_idle = (phase % 4 == 1) || (phase == 2);
         write_capacity((phase == 2) ? CAP_WIDTH'(60) : pick_capacity());
         if (phase == 2) holds_wanted++;
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 40) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 20);
            queue_random_string(len, $urandom_range(0, 9) != 0,
                                (phase == 3) && (bytes_queued == phase_start));
         end
      end
      wait_quiet();
      phase_no_idle = 1'b0;

      // A string left open while the capacity drops below its length: the
      // buffer counts as full until the terminator reports and clears.
      write_capacity(CAP_WIDTH'(60));
      queue_byte(BYTE_NUL);
      repeat (25) queue_byte(8'($urandom_range(33, 126)));
      wait_quiet();
      write_capacity(CAP_WIDTH'(5));
      queue_byte(8'h78);
      queue_byte(BYTE_TAB);
      queue_byte(8'hC3);
      queue_byte(BYTE_NUL);

      // One string back to back under the all-ones capacity, which
      // saturates to the buffer size.
      wait_quiet();
      phase_no_idle = 1'b1;
      write_capacity('1);
      repeat (40) queue_byte(8'($urandom_range(33, 126)));
      queue_byte(BYTE_NUL);
      wait_quiet();
      phase_no_idle = 1'b0;

      // Back to the reset capacity for a few short strings.
      write_capacity(CAP_RESET);
      repeat (4) queue_random_string($urandom_range(1, 15), 1'b1, 1'b0);
      wait_quiet();

      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : run_limit
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
